@@ hdl/plpa_pkg.sv @@
// package for the polyline length and polygon area block
// holds widths, payload structs and status codes; no dependencies
package plpa_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int MAX_POINTS = 1024;
  localparam int MIN_POINTS = 3;

  localparam int IN_W    = 16;
  localparam int LEN_W   = 35;
  localparam int AREA_W  = 40;
  localparam int CROSS_W = 48;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int MUL_W  = COORD_BITS + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = PROD_W;
  localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int ITER_W = $clog2(ROOT_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_SHUT = 2'd1,
    STAT_FEW_PTS  = 2'd2
  } status_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [IN_W-1:0] point_x;
    logic signed [IN_W-1:0] point_y;
    logic                   last_point;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  path_length;
    logic [AREA_W-1:0] enclosed_area;
    status_e           status;
  } out_item_t;

  // one classified vertex: current point, previous point, run position
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t px;
    coord_t py;
    logic   first;
    logic   last;
  } seg_item_t;

endpackage

@@ hdl/plpa_front.sv @@
// front end: takes vertex transfers, pairs each vertex with the previous
// one and marks run start; uses plpa_pkg
module plpa_front import plpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  input  logic      q_full_i,
  output logic      push_o,
  output seg_item_t push_data_o
);

  coord_t x, y;
  coord_t prev_x_q, prev_y_q;
  logic   run_start_q;

  assign x = in_data_i.point_x[COORD_BITS-1:0];
  assign y = in_data_i.point_y[COORD_BITS-1:0];

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    push_data_o.x     = x;
    push_data_o.y     = y;
    push_data_o.px    = prev_x_q;
    push_data_o.py    = prev_y_q;
    push_data_o.first = run_start_q;
    push_data_o.last  = in_data_i.last_point;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      run_start_q <= 1'b1;
    end else if (push_o) begin
      prev_x_q    <= x;
      prev_y_q    <= y;
      run_start_q <= in_data_i.last_point;
    end
  end

endmodule

@@ hdl/plpa_queue.sv @@
// short queue between front and back end
// depends on plpa_pkg for depth and entry type
module plpa_queue import plpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  seg_item_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output seg_item_t data_o
);

  seg_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ hdl/plpa_back.sv @@
// back end: shared multiplier, bit-serial square root, saturating sums and
// the result register; depends on plpa_pkg
module plpa_back import plpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      closed_mode_i,
  input  logic      q_valid_i,
  input  seg_item_t q_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ROOT = 4'b0100,
    S_ACC  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    MS_DXX = 2'd0,
    MS_DYY = 2'd1,
    MS_PXY = 2'd2,
    MS_XPY = 2'd3
  } mul_step_e;

  state_e    state_q;
  mul_step_e step_q;
  seg_item_t cur_q;

  logic signed [PROD_W-1:0] dxx_q, dyy_q, pxy_q, xpy_q;
  logic [RAD_W-1:0]         rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [ITER_W-1:0]        iter_q;

  coord_t                   first_x_q, first_y_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [LEN_W-1:0]         len_q;
  logic signed [CROSS_W-1:0] cross_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic signed [MUL_W-1:0]  dx, dy, mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SQ_W-1:0]          sq;
  logic [REM_W-1:0]         rem_sh, trial;
  logic                     root_bit;

  logic [CNT_W-1:0]          cnt_new;
  logic [LEN_W:0]            len_sum;
  logic [LEN_W-1:0]          len_next;
  logic signed [CROSS_W:0]   cross_sum;
  logic signed [CROSS_W-1:0] cross_next;
  logic [CROSS_W-1:0]        cross_mag;
  logic [CROSS_W-2:0]        area_full;
  logic [AREA_W-1:0]         area_sat;
  coord_t                    fx, fy;
  status_e                   stat;
  out_item_t                 res;
  logic                      acc_go, out_load;

  assign pop_o = (state_q == S_IDLE) && q_valid_i;

  // segment deltas and multiplier operand select
  always_comb begin
    dx = MUL_W'(cur_q.x) - MUL_W'(cur_q.px);
    dy = MUL_W'(cur_q.y) - MUL_W'(cur_q.py);
    case (step_q)
      MS_DXX: begin
        mul_a = dx;
        mul_b = dx;
      end
      MS_DYY: begin
        mul_a = dy;
        mul_b = dy;
      end
      MS_PXY: begin
        mul_a = MUL_W'(cur_q.px);
        mul_b = MUL_W'(cur_q.y);
      end
      MS_XPY: begin
        mul_a = MUL_W'(cur_q.x);
        mul_b = MUL_W'(cur_q.py);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // one root digit per cycle
  always_comb begin
    sq       = SQ_W'(dxx_q) + SQ_W'(dyy_q);
    rem_sh   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    root_bit = (rem_sh >= trial);
  end

  // accumulate and classify
  always_comb begin
    cnt_new = (cnt_q < CNT_W'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;

    len_sum  = {1'b0, len_q} + (LEN_W + 1)'(root_q);
    len_next = cur_q.first ? len_q : (len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0]);

    cross_sum = (CROSS_W + 1)'(cross_q) + (CROSS_W + 1)'(pxy_q) - (CROSS_W + 1)'(xpy_q);
    if (cur_q.first) begin
      cross_next = cross_q;
    end else if (cross_sum[CROSS_W] != cross_sum[CROSS_W-1]) begin
      cross_next = cross_sum[CROSS_W] ? {1'b1, {(CROSS_W - 1){1'b0}}}
                                      : {1'b0, {(CROSS_W - 1){1'b1}}};
    end else begin
      cross_next = cross_sum[CROSS_W-1:0];
    end

    cross_mag = cross_next[CROSS_W-1] ? (~cross_next + 1'b1) : cross_next;
    area_full = cross_mag[CROSS_W-1:1];
    area_sat  = (area_full[CROSS_W-2:AREA_W] != '0) ? '1 : area_full[AREA_W-1:0];

    fx = cur_q.first ? cur_q.x : first_x_q;
    fy = cur_q.first ? cur_q.y : first_y_q;

    if (!closed_mode_i) begin
      stat = STAT_OK;
    end else if (cur_q.x != fx || cur_q.y != fy) begin
      stat = STAT_NOT_SHUT;
    end else if (cnt_new < CNT_W'(MIN_POINTS)) begin
      stat = STAT_FEW_PTS;
    end else begin
      stat = STAT_OK;
    end

    res.status        = stat;
    res.path_length   = (stat == STAT_OK) ? len_next : '0;
    res.enclosed_area = (closed_mode_i && stat == STAT_OK) ? area_sat : '0;

    acc_go   = !(cur_q.last && out_valid_q && out_stall_i);
    out_load = (state_q == S_ACC) && cur_q.last && acc_go;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (state_q == S_MUL) begin
      case (step_q)
        MS_DXX:  dxx_q <= prod;
        MS_DYY:  dyy_q <= prod;
        MS_PXY:  pxy_q <= prod;
        MS_XPY:  xpy_q <= prod;
        default: dxx_q <= prod;
      endcase
    end
    if (state_q == S_MUL && step_q == MS_XPY) begin
      rad_q  <= RAD_W'(sq) << (2 * FRAC_BITS);
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == S_ROOT) begin
      rad_q  <= rad_q << 2;
      rem_q  <= root_bit ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], root_bit};
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= MS_DXX;
      iter_q      <= '0;
      first_x_q   <= '0;
      first_y_q   <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      cross_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            step_q  <= MS_DXX;
            state_q <= q_data_i.first ? S_ACC : S_MUL;
          end
        end
        S_MUL: begin
          step_q <= mul_step_e'(step_q + 1'b1);
          if (step_q == MS_XPY) begin
            iter_q  <= '0;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == ITER_W'(ROOT_W - 1)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_go) begin
            if (cur_q.last) begin
              cnt_q   <= '0;
              len_q   <= '0;
              cross_q <= '0;
            end else begin
              cnt_q   <= cnt_new;
              len_q   <= len_next;
              cross_q <= cross_next;
            end
            if (cur_q.first) begin
              first_x_q <= cur_q.x;
              first_y_q <= cur_q.y;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && iter_q == ITER_W'(ROOT_W - 1)) |=> (state_q == S_ACC))
    else $error("square root did not finish after its last digit");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond its limit");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res.status != STAT_OK)
      |=> (out_q.path_length == '0 && out_q.enclosed_area == '0))
    else $error("error result carries nonzero length or area");

  a_open_no_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !closed_mode_i) |=> (out_q.enclosed_area == '0 && out_q.status == STAT_OK))
    else $error("open mode result carries area or error");

endmodule

@@ hdl/polyline_length_polygon_area_top.sv @@
// top level of the polyline length and polygon area block; uses plpa_pkg,
// plpa_front, plpa_queue and plpa_back
// a segment vertex goes through the back end in order: dequeue, products dx*dx, dy*dy, px*y, x*py
// on the shared multiplier, a ROOT_W-digit square root and accumulate; the first vertex of a run goes
// from dequeue to accumulate; the result register loads when a run's closing vertex is accumulated
// reset clears all running sums and sets closed mode; config write takes effect next cycle
module polyline_length_polygon_area_top import plpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic      closed_mode_q;
  logic      push, full, pop, q_valid;
  seg_item_t push_data, q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      closed_mode_q <= cfg_data_i;
    end
  end

  plpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  plpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  plpa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .closed_mode_i (closed_mode_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

@@ tb/sv/plpa_check.sv @@
// checker for the polyline length and polygon area block: watches the vertex,
// result and mode channels, predicts each result and compares it field by field
// depends on plpa_pkg
module plpa_check import plpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic      cfg_data_i,
  output int        pending_o,
  output int        fail_count_o
);

  localparam logic [63:0] LEN_LIMIT  = (64'd1 << LEN_W) - 64'd1;
  localparam logic [63:0] AREA_LIMIT = (64'd1 << AREA_W) - 64'd1;
  localparam longint      CROSS_HI   = (longint'(1) << (CROSS_W - 1)) - 1;
  localparam longint      CROSS_LO   = -CROSS_HI - 1;

  logic        closed_mode;
  coord_t      first_x, first_y, prev_x, prev_y;
  int unsigned vertex_count;
  logic [63:0] length_acc;
  longint      cross_acc;
  out_item_t   expected_totals[$];
  out_item_t   oldest;
  int          fails;

  function automatic void clear_run();
    first_x      = '0;
    first_y      = '0;
    prev_x       = '0;
    prev_y       = '0;
    vertex_count = 0;
    length_acc   = '0;
    cross_acc    = 0;
  endfunction

  function automatic void trace_vertex(input in_item_t v);
    coord_t      x, y;
    longint      dx, dy, term;
    logic [63:0] rad, rem, root, trial, seg, mag;
    out_item_t   res;
    x = v.point_x;
    y = v.point_y;
    if (vertex_count == 0) begin
      first_x = x;
      first_y = y;
    end else begin
      dx  = longint'(x) - longint'(prev_x);
      dy  = longint'(y) - longint'(prev_y);
      rad = 64'(dx * dx + dy * dy) << (2 * FRAC_BITS);
      rem  = '0;
      root = '0;
      // digit-by-digit integer square root
      for (int i = 62; i >= 0; i -= 2) begin
        rem   = (rem << 2) | ((rad >> i) & 64'd3);
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      seg  = root;
      term = longint'(prev_x) * longint'(y) - longint'(x) * longint'(prev_y);
      if (seg > LEN_LIMIT - length_acc) length_acc = LEN_LIMIT;
      else length_acc = length_acc + seg;
      cross_acc = cross_acc + term;
      if (cross_acc > CROSS_HI) cross_acc = CROSS_HI;
      if (cross_acc < CROSS_LO) cross_acc = CROSS_LO;
    end
    prev_x = x;
    prev_y = y;
    if (vertex_count < MAX_POINTS) vertex_count++;
    if (!v.last_point) return;

    res.path_length   = length_acc[LEN_W-1:0];
    res.enclosed_area = '0;
    res.status        = STAT_OK;
    if (closed_mode) begin
      if (x != first_x || y != first_y) res.status = STAT_NOT_SHUT;
      else if (vertex_count < MIN_POINTS) res.status = STAT_FEW_PTS;
      if (res.status != STAT_OK) begin
        res.path_length = '0;
      end else begin
        mag = (cross_acc < 0) ? 64'(-cross_acc) : 64'(cross_acc);
        mag = mag >> 1;
        if (mag > AREA_LIMIT) mag = AREA_LIMIT;
        res.enclosed_area = mag[AREA_W-1:0];
      end
    end
    expected_totals.push_back(res);
    clear_run();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_mode = 1'b1;
      clear_run();
      expected_totals.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) closed_mode = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_totals.size() == 0) begin
          fails++;
          $display("%0t: result with none expected: length %0d area %0d status %0d",
                   $time, out_data_i.path_length, out_data_i.enclosed_area,
                   out_data_i.status);
        end else begin
          oldest = expected_totals.pop_front();
          if (out_data_i.path_length !== oldest.path_length) begin
            fails++;
            $display("%0t: path_length expected %0d, got %0d", $time,
                     oldest.path_length, out_data_i.path_length);
          end
          if (out_data_i.enclosed_area !== oldest.enclosed_area) begin
            fails++;
            $display("%0t: enclosed_area expected %0d, got %0d", $time,
                     oldest.enclosed_area, out_data_i.enclosed_area);
          end
          if (out_data_i.status !== oldest.status) begin
            fails++;
            $display("%0t: status expected %0d, got %0d", $time,
                     oldest.status, out_data_i.status);
          end
        end
      end
      if (in_valid_i && !in_stall_i) trace_vertex(in_data_i);
      pending_o    <= expected_totals.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// top of the polyline length and polygon area testbench: clock, reset, vertex
// stimulus, result stall pattern and mode writes; depends on plpa_pkg,
// plpa_check and polyline_length_polygon_area_top
module testbench import plpa_pkg::*; ();

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TICK} stall_style_e;

  localparam int SETTLE_CYCLES = 40;
  localparam int SQUARE_LAPS   = 270;
  localparam int PHASE_ITEMS   = 60;
  localparam logic signed [IN_W-1:0] COORD_LO = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] COORD_HI = {1'b0, {(IN_W-1){1'b1}}};

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      cfg_ready;
  int        pending;
  int        fail_count;

  int           burst_left  = 0;
  stall_style_e stall_style = STALL_NONE;
  int           stall_left  = 0;
  int           tick        = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  polyline_length_polygon_area_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  plpa_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(100, 2000);
    end
    stall_left--;
    tick++;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default:     out_stall <= ((tick % 5) < 3);
    endcase
  end

  function automatic logic signed [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_LO;
      1:       return COORD_HI;
      2, 3:    return IN_W'(int'($urandom_range(0, 64)) - 32);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // one vertex transfer; a new burst starts with a random gap with a chance of three in four
  task automatic push_vertex(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                             input logic last);
    in_item_t item;
    item.point_x    = x;
    item.point_y    = y;
    item.last_point = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_closed_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent, n;
    logic signed [IN_W-1:0] fx, fy;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_closed_mode(1'b1);
    // single vertex, repeated vertex, extreme triangle, open ring, short open ring
    push_vertex(5, -3, 1'b1);
    push_vertex(7, 7, 1'b0);
    push_vertex(7, 7, 1'b1);
    push_vertex(COORD_LO, COORD_LO, 1'b0);
    push_vertex(COORD_HI, COORD_LO, 1'b0);
    push_vertex(COORD_HI, COORD_HI, 1'b0);
    push_vertex(COORD_LO, COORD_LO, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(1, 1, 1'b0);
    push_vertex(-5, 7, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(3, 4, 1'b1);
    drain_results();
    write_closed_mode(1'b0);
    push_vertex(COORD_HI, COORD_HI, 1'b0);
    push_vertex(COORD_LO, COORD_LO, 1'b1);
    push_vertex(1, 2, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(3, 4, 1'b0);
    push_vertex(0, 0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_closed_mode(p == 0 ? 1'b1 : p == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) drain_results();
        case ($urandom_range(0, 9))
          7: begin
            // ring that ends away from its start
            n = $urandom_range(2, 8);
            for (int j = 0; j < n; j++) push_vertex(rand_coord(), rand_coord(), j == n - 1);
            sent += n;
          end
          8: begin
            fx = rand_coord();
            fy = rand_coord();
            case ($urandom_range(0, 2))
              0: begin
                push_vertex(fx, fy, 1'b1);
                sent += 1;
              end
              1: begin
                push_vertex(fx, fy, 1'b0);
                push_vertex(fx, fy, 1'b1);
                sent += 2;
              end
              default: begin
                push_vertex(fx, fy, 1'b0);
                push_vertex(rand_coord(), rand_coord(), 1'b1);
                sent += 2;
              end
            endcase
          end
          9: begin
            // loose stream with random end marks
            n = $urandom_range(1, 15);
            for (int j = 0; j < n; j++)
              push_vertex(rand_coord(), rand_coord(),
                          (j == n - 1) || ($urandom_range(0, 4) == 0));
            sent += n;
          end
          default: begin
            // well-formed polygon that returns to its first vertex
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(2, 10);
            fx = rand_coord();
            fy = rand_coord();
            push_vertex(fx, fy, 1'b0);
            repeat (n - 1) push_vertex(rand_coord(), rand_coord(), 1'b0);
            push_vertex(fx, fy, 1'b1);
            sent += n + 1;
          end
        endcase
      end
      if (p == 3) begin
        // laps around the extreme square: saturates count and area
        drain_results();
        write_closed_mode(1'b1);
        for (int i = 0; i < 4 * SQUARE_LAPS; i++)
          push_vertex((i % 4 == 1 || i % 4 == 2) ? COORD_HI : COORD_LO,
                      (i % 4 >= 2) ? COORD_HI : COORD_LO, 1'b0);
        push_vertex(COORD_LO, COORD_LO, 1'b1);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
